// ----- rtl/mip_box_downsample_2x2_macros.svh -----
// assertion helpers shared by the rtl files
`ifndef MIP_BOX_DOWNSAMPLE_2X2_MACROS_SVH
`define MIP_BOX_DOWNSAMPLE_2X2_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define MIPDS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define MIPDS_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define MIPDS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define MIPDS_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

// ----- rtl/mipds_pkg.sv -----
package mipds_pkg;

  localparam int CHAN_W       = 32;
  localparam int PAIR_W       = CHAN_W + 1;
  localparam int SUM_W        = CHAN_W + 2;
  localparam int NUM_CHAN     = 4;
  localparam int WIDTH_REG_W  = 13;
  localparam int HEIGHT_REG_W = 16;
  localparam int CFG_DATA_W   = 16;
  localparam int CFG_IDX_W    = 1;

  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 13'd4096;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 16'd4096;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SOURCE_WIDTH  = 1'b0,
    REG_SOURCE_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef logic signed [CHAN_W-1:0] chan_t;
  typedef logic signed [PAIR_W-1:0] pair_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  // per-pixel decisions made at accept time
  typedef struct packed {
    logic hold;        // even column: keep pixel for the next one
    logic pair_self;   // one-column source: pixel pairs with itself
    logic store;       // even row: write pair sum to the line store
    logic emit;        // produces a result
    logic twice;       // one-row source: pair sum counts for both rows
    logic frame_done;
  } item_ctl_t;

endpackage

// ----- rtl/mipds_if.sv -----
interface mipds_pix_if;
  logic valid;
  logic ready;
  logic signed [mipds_pkg::CHAN_W-1:0] in_red;
  logic signed [mipds_pkg::CHAN_W-1:0] in_green;
  logic signed [mipds_pkg::CHAN_W-1:0] in_blue;
  logic signed [mipds_pkg::CHAN_W-1:0] in_alpha;

  modport source (output valid, in_red, in_green, in_blue, in_alpha, input ready);
  modport sink (input valid, in_red, in_green, in_blue, in_alpha, output ready);
endinterface

interface mipds_res_if;
  logic valid;
  logic ready;
  logic signed [mipds_pkg::CHAN_W-1:0] out_red;
  logic signed [mipds_pkg::CHAN_W-1:0] out_green;
  logic signed [mipds_pkg::CHAN_W-1:0] out_blue;
  logic signed [mipds_pkg::CHAN_W-1:0] out_alpha;
  logic frame_done;

  modport source (output valid, out_red, out_green, out_blue, out_alpha, frame_done,
                  input ready);
  modport sink (input valid, out_red, out_green, out_blue, out_alpha, frame_done,
                output ready);
endinterface

// ----- rtl/mipds_ram.sv -----
module mipds_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic                                  re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/mipds_seq.sv -----
`include "mip_box_downsample_2x2_macros.svh"

module mipds_seq #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [mipds_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [mipds_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                  acc_i,
  output mipds_pkg::item_ctl_t                  ctl_o,
  output logic [((MAX_WIDTH + 1) / 2 > 1 ? $clog2((MAX_WIDTH + 1) / 2) : 1)-1:0] addr_o
);

  localparam int PAIR_DEPTH = (MAX_WIDTH + 1) / 2;
  localparam int AW  = PAIR_DEPTH > 1 ? $clog2(PAIR_DEPTH) : 1;
  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int WEW = $clog2(MAX_WIDTH + 1);
  localparam int HW  = mipds_pkg::HEIGHT_REG_W;

  logic [mipds_pkg::WIDTH_REG_W-1:0] width_q;
  logic [HW-1:0]                     height_q;
  logic [CW-1:0]                     col_q, col_d;
  logic [HW-1:0]                     row_q, row_d;

  logic [WEW-1:0] w_eff, w_half;
  logic [HW-1:0]  h_eff, h_half, orow;
  logic           w_big, single_col, single_row, last_col, last_row;
  logic [AW-1:0]  pidx;

  // clamp the registers to the usable range
  always_comb begin
    w_big = 32'(width_q) > 32'(MAX_WIDTH);
    if (width_q == '0) begin
      w_eff = WEW'(1);
    end else if (w_big) begin
      w_eff = WEW'(MAX_WIDTH);
    end else begin
      w_eff = WEW'(width_q);
    end
    h_eff      = (height_q == '0) ? HW'(1) : height_q;
    w_half     = (w_eff < WEW'(4)) ? WEW'(1) : (w_eff >> 1);
    h_half     = (h_eff < HW'(4)) ? HW'(1) : (h_eff >> 1);
    single_col = w_eff == WEW'(1);
    single_row = h_eff == HW'(1);
    last_col   = WEW'(col_q) == w_eff - WEW'(1);
    last_row   = row_q == h_eff - HW'(1);
    pidx       = single_col ? '0 : AW'(col_q >> 1);
    orow       = single_row ? '0 : (row_q >> 1);
  end

  always_comb begin
    ctl_o.hold       = !single_col && !col_q[0];
    ctl_o.pair_self  = single_col;
    ctl_o.store      = (single_col || col_q[0]) && !single_row && !row_q[0];
    ctl_o.emit       = (single_col || col_q[0]) && (single_row || row_q[0]);
    ctl_o.twice      = single_row;
    ctl_o.frame_done = (WEW'(pidx) == w_half - WEW'(1)) && (orow == h_half - HW'(1));
    addr_o           = pidx;
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cfg_we_i) begin
      col_d = '0;
      row_d = '0;
    end else if (acc_i) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_q + HW'(1);
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= mipds_pkg::WIDTH_RESET;
      height_q <= mipds_pkg::HEIGHT_RESET;
      col_q    <= '0;
      row_q    <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      if (cfg_we_i) begin
        unique case (mipds_pkg::cfg_reg_e'(cfg_idx_i))
          mipds_pkg::REG_SOURCE_WIDTH:  width_q  <= cfg_data_i[mipds_pkg::WIDTH_REG_W-1:0];
          mipds_pkg::REG_SOURCE_HEIGHT: height_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  `MIPDS_ASSERT_IMP(a_col_in_range, clk_i, rst_ni, 1'b1, WEW'(col_q) < w_eff, "column past row end")
  `MIPDS_ASSERT_IMP(a_row_in_range, clk_i, rst_ni, 1'b1, row_q < h_eff, "row past image end")
  `MIPDS_ASSERT_NXT(a_col_wrap, clk_i, rst_ni, acc_i && last_col, col_q == '0, "column did not wrap")

endmodule

// ----- rtl/mip_box_downsample_2x2.sv -----
// channel  dir  handshake    payload
// pix_i    in   valid/ready  in_red in_green in_blue in_alpha (signed Q16.16)
// res_o    out  valid/ready  out_red out_green out_blue out_alpha frame_done
// cfg      in   cfg_we_i     cfg_idx_i selects source_width or source_height
//
// one source pixel per cycle unless a stalled output backs up the pipeline
// pipeline: position logic, pair add and line store access, block sum into
// the output register; the line store port sets the pace (at most one access a pixel)
// reset clears position and pipeline valids; the line store is not cleared,
// a register write restarts the frame
// a stalled output blocks the input once output, block sum and pixel stages are all full

`include "mip_box_downsample_2x2_macros.svh"

module mip_box_downsample_2x2 #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [mipds_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [mipds_pkg::CFG_DATA_W-1:0] cfg_data_i,
  mipds_pix_if.sink                        pix_i,
  mipds_res_if.source                      res_o
);

  localparam int PAIR_DEPTH = (MAX_WIDTH + 1) / 2;
  localparam int AW   = PAIR_DEPTH > 1 ? $clog2(PAIR_DEPTH) : 1;
  localparam int NC   = mipds_pkg::NUM_CHAN;
  localparam int CHW  = mipds_pkg::CHAN_W;
  localparam int SW   = mipds_pkg::SUM_W;
  localparam int RAMW = NC * SW;

  logic                 pix_acc;
  mipds_pkg::item_ctl_t acc_ctl;
  logic [AW-1:0]        acc_addr;

  // stage 1
  logic                           s1_v_q;
  mipds_pkg::item_ctl_t           s1_ctl_q;
  logic [AW-1:0]                  s1_addr_q;
  mipds_pkg::chan_t [NC-1:0]      s1_px_q;
  mipds_pkg::chan_t [NC-1:0]      held_q;
  mipds_pkg::pair_t [NC-1:0]      s1_pair;
  logic                           s1_adv;

  // stage 2
  logic                           s2_v_q;
  logic                           s2_twice_q;
  logic                           s2_done_q;
  mipds_pkg::pair_t [NC-1:0]      s2_pair_q;
  logic                           s2_free;

  // output register
  logic                           out_v_q;
  logic                           out_done_q;
  mipds_pkg::chan_t [NC-1:0]      out_q;
  mipds_pkg::chan_t [NC-1:0]      out_d;

  logic                           ram_we, ram_re;
  logic [RAMW-1:0]                ram_wdata, ram_rdata;

  mipds_seq #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .acc_i      (pix_acc),
    .ctl_o      (acc_ctl),
    .addr_o     (acc_addr)
  );

  assign s2_free     = !s2_v_q || !out_v_q || res_o.ready;
  assign s1_adv      = s2_free;
  assign pix_i.ready = !s1_v_q || s1_adv;
  assign pix_acc     = pix_i.valid && pix_i.ready;

  // horizontal pair sums
  always_comb begin
    for (int i = 0; i < NC; i++) begin
      if (s1_ctl_q.pair_self) begin
        s1_pair[i] = {s1_px_q[i], 1'b0};
      end else begin
        s1_pair[i] = {held_q[i][CHW-1], held_q[i]} + {s1_px_q[i][CHW-1], s1_px_q[i]};
      end
      ram_wdata[i*SW +: SW] = {s1_pair[i][CHW], s1_pair[i]};
    end
  end

  assign ram_we = s1_v_q && s1_adv && s1_ctl_q.store;
  assign ram_re = s1_v_q && s1_adv && s1_ctl_q.emit && !s1_ctl_q.twice;

  mipds_ram #(
    .WIDTH (RAMW),
    .DEPTH (PAIR_DEPTH)
  ) u_line (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (s1_addr_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (s1_addr_q),
    .rdata_o (ram_rdata)
  );

  // vertical sum and floor divide by four
  always_comb begin
    mipds_pkg::sum_t total;
    for (int i = 0; i < NC; i++) begin
      if (s2_twice_q) begin
        total = {s2_pair_q[i], 1'b0};
      end else begin
        total = ram_rdata[i*SW +: SW] + {s2_pair_q[i][CHW], s2_pair_q[i]};
      end
      out_d[i] = total[SW-1:2];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      // an empty pixel stage takes a beat even while the rest is stalled
      if (pix_i.ready) begin
        s1_v_q <= pix_acc;
      end
      if (s1_adv) begin
        s2_v_q <= s1_v_q && s1_ctl_q.emit;
      end
      if (s2_v_q && (!out_v_q || res_o.ready)) begin
        out_v_q <= 1'b1;
      end else if (res_o.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_acc) begin
      s1_ctl_q  <= acc_ctl;
      s1_addr_q <= acc_addr;
      s1_px_q   <= {pix_i.in_alpha, pix_i.in_blue, pix_i.in_green, pix_i.in_red};
    end
    if (s1_adv && s1_v_q) begin
      if (s1_ctl_q.hold) begin
        held_q <= s1_px_q;
      end
      s2_pair_q  <= s1_pair;
      s2_twice_q <= s1_ctl_q.twice;
      s2_done_q  <= s1_ctl_q.frame_done;
    end
    if (s2_v_q && (!out_v_q || res_o.ready)) begin
      out_q      <= out_d;
      out_done_q <= s2_done_q;
    end
  end

  assign res_o.valid      = out_v_q;
  assign res_o.out_red    = out_q[0];
  assign res_o.out_green  = out_q[1];
  assign res_o.out_blue   = out_q[2];
  assign res_o.out_alpha  = out_q[3];
  assign res_o.frame_done = out_done_q;

  `MIPDS_ASSERT_IMP(a_ram_one_access, clk_i, rst_ni, ram_we, !ram_re, "line store read and write together")
  `MIPDS_ASSERT_IMP(a_stall_holds_s1, clk_i, rst_ni, s2_v_q && out_v_q && !res_o.ready, !s1_adv && !ram_re, "pipeline moved under stall")
  `MIPDS_ASSERT_IMP(a_out_from_s2, clk_i, rst_ni, $rose(out_v_q), $past(s2_v_q), "result without block sum")

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps

module tb;
  import mipds_pkg::*;

  localparam int MAX_W        = 4096;
  localparam int PAIR_SLOTS   = MAX_W / 2;
  localparam int RANDOM_ITEMS = 1300;
  localparam int WIDE_ITEMS   = 160;
  localparam int TAIL_ITEMS   = 200;
  localparam int SETTLE       = 8;
  localparam int DRAIN_CYCLES = 20;
  localparam int LIMIT        = 1000000;

  typedef enum logic [1:0] {
    STEP_PIXEL,
    STEP_WRITE,
    STEP_HOLD
  } step_kind_e;

  typedef struct packed {
    step_kind_e       kind;
    logic [3:0][31:0] px;       // [0] red .. [3] alpha
    cfg_reg_e         reg_idx;
    logic [15:0]      data;
  } stim_step_t;

  typedef struct packed {
    logic [3:0][31:0] mean;
    logic             frame_done;
  } block_mean_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  mipds_pix_if pix_bus ();
  mipds_res_if res_bus ();

  mip_box_downsample_2x2 #(.MAX_WIDTH(MAX_W)) uut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .pix_i     (pix_bus),
    .res_o     (res_bus)
  );

  stim_step_t  pending[$];
  block_mean_t mean_queue[$];
  int          error_count = 0;
  int          cycle_count = 0;
  int          quiet_cycles = 0;
  logic        calm_tail = 1'b0;
  string       chan_name [4] = '{"red", "green", "blue", "alpha"};

  // predictor state
  logic [WIDTH_REG_W-1:0]  src_width  = WIDTH_RESET;
  logic [HEIGHT_REG_W-1:0] src_height = HEIGHT_RESET;
  sum_t                    row_pairs [4][PAIR_SLOTS];
  logic [3:0][31:0]        held_px = '0;
  int unsigned             col_pos = 0;
  int unsigned             row_pos = 0;

  task automatic flag_error(input string msg);
    error_count++;
    $display("%0t: %s", $time, msg);
  endtask

  function automatic int unsigned eff_width(input int unsigned w);
    return (w == 0) ? 1 : ((w > MAX_W) ? MAX_W : w);
  endfunction

  function automatic int unsigned eff_height(input int unsigned h);
    return (h == 0) ? 1 : h;
  endfunction

  function automatic void take_config(input cfg_reg_e idx, input logic [15:0] data);
    if (idx == REG_SOURCE_WIDTH) begin
      src_width = data[WIDTH_REG_W-1:0];
    end else begin
      src_height = data[HEIGHT_REG_W-1:0];
    end
    held_px = '0;
    col_pos = 0;
    row_pos = 0;
  endfunction

  function automatic void take_pixel(input logic [3:0][31:0] px);
    int unsigned w0, h0, w1, h1, slot, out_row;
    sum_t        cur [4];
    sum_t        pair [4];
    sum_t        total [4];
    sum_t        held_ext;
    sum_t        quarter;
    bit          have_pair;
    bit          emit;
    block_mean_t m;
    w0 = eff_width(src_width);
    h0 = eff_height(src_height);
    w1 = ((w0 >> 1) > 1) ? (w0 >> 1) : 1;
    h1 = ((h0 >> 1) > 1) ? (h0 >> 1) : 1;
    have_pair = 1'b0;
    emit = 1'b0;
    slot = 0;
    out_row = 0;
    for (int i = 0; i < 4; i++) begin
      cur[i] = $signed(px[i]);
    end
    if (w0 == 1) begin
      // one column: the pixel pairs with itself
      for (int i = 0; i < 4; i++) begin
        pair[i] = cur[i] + cur[i];
      end
      have_pair = 1'b1;
    end else begin
      slot = col_pos >> 1;
      if (col_pos % 2 == 0) begin
        held_px = px;
      end else begin
        for (int i = 0; i < 4; i++) begin
          held_ext = $signed(held_px[i]);
          pair[i] = held_ext + cur[i];
        end
        have_pair = 1'b1;
      end
    end
    if (have_pair) begin
      if (h0 == 1) begin
        for (int i = 0; i < 4; i++) begin
          total[i] = pair[i] + pair[i];
        end
        emit = 1'b1;
      end else if (row_pos % 2 == 0) begin
        for (int i = 0; i < 4; i++) begin
          row_pairs[i][slot] = pair[i];
        end
      end else begin
        for (int i = 0; i < 4; i++) begin
          total[i] = row_pairs[i][slot] + pair[i];
        end
        emit = 1'b1;
        out_row = row_pos >> 1;
      end
    end
    if (emit) begin
      for (int i = 0; i < 4; i++) begin
        quarter = total[i] >>> 2;
        m.mean[i] = quarter[31:0];
      end
      m.frame_done = (slot == w1 - 1) && (out_row == h1 - 1);
      mean_queue.push_back(m);
    end
    if (col_pos + 1 >= w0) begin
      col_pos = 0;
      row_pos = (row_pos + 1 >= h0) ? 0 : row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
  endfunction

  function automatic logic [31:0] rand_chan();
    case ($urandom_range(0, 9))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'hffff_ffff;
      3: return $urandom_range(0, 3);
      default: return $urandom();
    endcase
  endfunction

  function automatic void push_pixel(input logic [31:0] r, input logic [31:0] g,
                                     input logic [31:0] b, input logic [31:0] a);
    stim_step_t s;
    s = '0;
    s.kind = STEP_PIXEL;
    s.px = {a, b, g, r};
    pending.push_back(s);
  endfunction

  function automatic void push_rand_pixel();
    push_pixel(rand_chan(), rand_chan(), rand_chan(), rand_chan());
  endfunction

  function automatic void push_write(input cfg_reg_e idx, input logic [15:0] data);
    stim_step_t s;
    s = '0;
    s.kind = STEP_WRITE;
    s.reg_idx = idx;
    s.data = data;
    pending.push_back(s);
  endfunction

  function automatic void push_hold();
    stim_step_t s;
    s = '0;
    s.kind = STEP_HOLD;
    pending.push_back(s);
  endfunction

  function automatic void set_size(input logic [15:0] wdata, input logic [15:0] hdata);
    if ($urandom_range(0, 1) == 0) begin
      push_write(REG_SOURCE_WIDTH, wdata);
      push_write(REG_SOURCE_HEIGHT, hdata);
    end else begin
      push_write(REG_SOURCE_HEIGHT, hdata);
      push_write(REG_SOURCE_WIDTH, wdata);
    end
  endfunction

  // one setting, whole frames of random pixels, now and then cut short
  function automatic int queue_phase(input int unsigned w, input int unsigned h,
                                     input bit whole);
    int unsigned area;
    int          npix;
    int          hold_at;
    set_size({3'($urandom_range(0, 7)), 13'(w)}, 16'(h));
    area = eff_width(w) * eff_height(h);
    npix = area * ((area > 400) ? 1 : $urandom_range(1, 3));
    if (!whole && $urandom_range(0, 4) == 0) begin
      npix = $urandom_range(1, npix);
    end
    hold_at = (!whole && $urandom_range(0, 3) == 0) ? $urandom_range(0, npix - 1) : -1;
    for (int i = 0; i < npix; i++) begin
      if (i == hold_at) begin
        push_hold();
      end
      push_rand_pixel();
    end
    return npix;
  endfunction

  function automatic int unsigned pick_width();
    case ($urandom_range(0, 19))
      0:                  return 0;
      1:                  return 1;
      16, 17, 18:         return $urandom_range(13, 80);
      19:                 return $urandom_range(100, 300);
      default:            return $urandom_range(2, 12);
    endcase
  endfunction

  function automatic int unsigned pick_height(input int unsigned w);
    if (w > 64) begin
      return $urandom_range(0, 4);
    end
    case ($urandom_range(0, 9))
      0:       return $urandom_range(10, 40);
      default: return $urandom_range(0, 9);
    endcase
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  // source side: pixels, register writes and pauses in queue order
  int send_gap  = 0;
  int send_calm = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    logic             nxt_valid;
    logic [3:0][31:0] nxt_px;
    logic             nxt_we;
    cfg_reg_e         nxt_idx;
    logic [15:0]      nxt_data;
    if (!rst_ni) begin
      pix_bus.valid    <= 1'b0;
      pix_bus.in_red   <= '0;
      pix_bus.in_green <= '0;
      pix_bus.in_blue  <= '0;
      pix_bus.in_alpha <= '0;
      cfg_we_i         <= 1'b0;
      cfg_idx_i        <= REG_SOURCE_WIDTH;
      cfg_data_i       <= '0;
      send_gap = 0;
      send_calm = 0;
    end else begin
      nxt_valid = pix_bus.valid && !pix_bus.ready;
      nxt_px = {pix_bus.in_alpha, pix_bus.in_blue, pix_bus.in_green, pix_bus.in_red};
      nxt_we = 1'b0;
      nxt_idx = cfg_reg_e'(cfg_idx_i);
      nxt_data = cfg_data_i;
      if (!nxt_valid && pending.size() != 0) begin
        case (pending[0].kind)
          STEP_PIXEL: begin
            if (send_gap > 0) begin
              send_gap--;
            end else if (!calm_tail && send_calm == 0 && $urandom_range(0, 7) == 0) begin
              send_gap = $urandom_range(0, 16);
              send_calm = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 120) : 0;
            end else begin
              if (send_calm > 0) begin
                send_calm--;
              end
              nxt_valid = 1'b1;
              nxt_px = pending[0].px;
              void'(pending.pop_front());
            end
          end
          STEP_WRITE: begin
            // only once the block has drained
            if (!pix_bus.valid && mean_queue.size() == 0 && quiet_cycles >= SETTLE) begin
              nxt_we = 1'b1;
              nxt_idx = pending[0].reg_idx;
              nxt_data = pending[0].data;
              void'(pending.pop_front());
            end
          end
          default: begin
            if (!pix_bus.valid && mean_queue.size() == 0) begin
              void'(pending.pop_front());
            end
          end
        endcase
      end
      pix_bus.valid    <= nxt_valid;
      pix_bus.in_red   <= nxt_px[0];
      pix_bus.in_green <= nxt_px[1];
      pix_bus.in_blue  <= nxt_px[2];
      pix_bus.in_alpha <= nxt_px[3];
      cfg_we_i         <= nxt_we;
      cfg_idx_i        <= nxt_idx;
      cfg_data_i       <= nxt_data;
      calm_tail        <= (pending.size() <= TAIL_ITEMS);
    end
  end

  // sink side stalls
  int stall_left = 0;
  int stall_calm = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_bus.ready <= 1'b0;
      stall_left = 0;
      stall_calm = 0;
    end else begin
      if (stall_left > 0) begin
        stall_left--;
        res_bus.ready <= 1'b0;
      end else if (!calm_tail && stall_calm == 0 && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 16);
        stall_calm = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 120) : 0;
        res_bus.ready <= 1'b0;
      end else begin
        if (stall_calm > 0) begin
          stall_calm--;
        end
        res_bus.ready <= 1'b1;
      end
    end
  end

  // predict on every accepted pixel beat, check every result beat
  always @(posedge clk_i) begin
    logic [3:0][31:0] got;
    block_mean_t      want;
    logic             pix_beat;
    logic             res_beat;
    if (rst_ni) begin
      pix_beat = pix_bus.valid && pix_bus.ready;
      res_beat = res_bus.valid && res_bus.ready;
      if (cfg_we_i) begin
        take_config(cfg_reg_e'(cfg_idx_i), cfg_data_i);
      end
      if (pix_beat) begin
        take_pixel({pix_bus.in_alpha, pix_bus.in_blue, pix_bus.in_green, pix_bus.in_red});
      end
      if (res_beat) begin
        if (mean_queue.size() == 0) begin
          flag_error("result beat with no block mean pending");
        end else begin
          want = mean_queue.pop_front();
          got = {res_bus.out_alpha, res_bus.out_blue, res_bus.out_green, res_bus.out_red};
          for (int i = 0; i < 4; i++) begin
            if (got[i] !== want.mean[i]) begin
              flag_error($sformatf("%s: got %h, want %h", chan_name[i], got[i],
                                   want.mean[i]));
            end
          end
          if (res_bus.frame_done !== want.frame_done) begin
            flag_error($sformatf("frame_done: got %b, want %b", res_bus.frame_done,
                                 want.frame_done));
          end
        end
      end
      quiet_cycles <= (pix_beat || res_beat) ? 0 :
                      ((quiet_cycles < 1000) ? quiet_cycles + 1 : quiet_cycles);
    end
  end

  initial begin
    int          made;
    int unsigned w;
    bit          big_done;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_SOURCE_WIDTH;
    cfg_data_i = '0;
    pix_bus.valid = 1'b0;
    pix_bus.in_red = '0;
    pix_bus.in_green = '0;
    pix_bus.in_blue = '0;
    pix_bus.in_alpha = '0;
    res_bus.ready = 1'b0;

    // reset size, start of the first row of a large frame only
    push_pixel(32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 32'h0);
    push_pixel(32'h0001_0000, 32'hffff_0000, 32'h0000_8000, 32'h1);
    // single pixel image
    push_write(REG_SOURCE_WIDTH, 16'd1);
    push_write(REG_SOURCE_HEIGHT, 16'd1);
    push_pixel(32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 32'h1);
    // zero sizes act as one
    push_write(REG_SOURCE_WIDTH, 16'd0);
    push_write(REG_SOURCE_HEIGHT, 16'd0);
    push_pixel(32'h7fff_ffff, 32'h8000_0000, 32'h0000_8000, 32'hffff_fffd);
    // one row: rounding towards minus infinity
    push_write(REG_SOURCE_WIDTH, 16'd2);
    push_write(REG_SOURCE_HEIGHT, 16'd1);
    push_pixel(32'h7fff_ffff, 32'h8000_0000, 32'h1, 32'hffff_ffff);
    push_pixel(32'h7fff_ffff, 32'h8000_0000, 32'h2, 32'hffff_fffe);
    // 2x2, cut after the first row, restarted by a write
    push_write(REG_SOURCE_HEIGHT, 16'd2);
    push_pixel(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    push_pixel(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    push_write(REG_SOURCE_HEIGHT, 16'd2);
    push_pixel(32'h1, 32'hffff_ffff, 32'h3, 32'h8000_0000);
    push_pixel(32'h0, 32'h0, 32'h0, 32'h8000_0000);
    push_pixel(32'h0, 32'hffff_ffff, 32'h0, 32'h8000_0000);
    push_pixel(32'h0, 32'hffff_ffff, 32'h0, 32'h8000_0000);
    // odd width and odd height
    push_write(REG_SOURCE_WIDTH, 16'd3);
    push_write(REG_SOURCE_HEIGHT, 16'd3);
    for (int i = 0; i < 9; i++) begin
      push_rand_pixel();
    end
    // one column
    push_write(REG_SOURCE_WIDTH, 16'd1);
    push_write(REG_SOURCE_HEIGHT, 16'd4);
    for (int i = 0; i < 4; i++) begin
      push_rand_pixel();
    end

    made = 0;
    big_done = 1'b0;
    while (made < RANDOM_ITEMS) begin
      if (!big_done && made > RANDOM_ITEMS / 2) begin
        // widest setting (register above the store size), tallest image,
        // start of the top row only
        set_size(16'hffff, 16'hffff);
        for (int i = 0; i < WIDE_ITEMS; i++) begin
          push_rand_pixel();
        end
        made += WIDE_ITEMS;
        push_hold();
        big_done = 1'b1;
      end
      w = pick_width();
      made += queue_phase(w, pick_height(w), 1'b0);
      if ($urandom_range(0, 7) == 0) begin
        push_hold();
      end
    end
    // no idling from here on
    made += queue_phase(8, 6, 1'b1);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending.size() != 0 || pix_bus.valid || mean_queue.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

// ----- mip_box_downsample_2x2.f -----
+incdir+rtl
rtl/mipds_pkg.sv
rtl/mipds_if.sv
rtl/mipds_ram.sv
rtl/mipds_seq.sv
rtl/mip_box_downsample_2x2.sv
tb/tb.sv
